// ===== sv/thread_slot_dispatch_tick_macros.svh =====
// ----------------------------------------------------------------------------
// thread_slot_dispatch_tick assertion macros
// Concurrent assertion wrappers, empty when synthesizing.
// ----------------------------------------------------------------------------
`ifndef THREAD_SLOT_DISPATCH_TICK_MACROS_SVH
`define THREAD_SLOT_DISPATCH_TICK_MACROS_SVH

`ifndef SYNTHESIS
// invariant that holds at every edge outside reset
`define TSD_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("tsd invariant violated");
// condition in one cycle implies consequence in the same cycle
`define TSD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsd same-cycle check failed");
// condition in one cycle implies consequence in the next
`define TSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsd next-cycle check failed");
`else
`define TSD_ASSERT_ALWAYS(lbl, expr)
`define TSD_ASSERT_SAME(lbl, ante, cons)
`define TSD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/tsd_pkg.sv =====
// ----------------------------------------------------------------------------
// tsd_pkg
// Types and constants of the thread slot dispatcher.
// ----------------------------------------------------------------------------
package tsd_pkg;

  localparam int CORES   = 4;
  localparam int THREADS = 2;
  localparam int SLOTS   = CORES * THREADS;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);

  localparam int OP_W         = 2;
  localparam int KIND_W       = 3;
  localparam int OUT_SLOT_W   = 3;
  localparam int PROC_W       = 8;
  localparam int REM_W        = 16;
  localparam int PRIO_W       = 8;

  localparam logic [OP_W-1:0] OP_DISPATCH = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd1;
  localparam logic [OP_W-1:0] OP_PREEMPT  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_DISPATCHED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NO_SLOT    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FINISHED   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_PREEMPTED  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_NOTHING    = 3'd4;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } tsd_state_t;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [PROC_W-1:0] process_id;
    logic [REM_W-1:0]  remaining_time;
    logic [PRIO_W-1:0] priority_req;
  } tsd_in_t;

  typedef struct packed {
    logic [KIND_W-1:0]     out_kind;
    logic [OUT_SLOT_W-1:0] out_slot;
    logic [PROC_W-1:0]     out_process;
    logic [REM_W-1:0]      out_remaining;
    logic [PRIO_W-1:0]     out_priority;
    logic                  last;
  } tsd_out_t;

endpackage

// ===== sv/thread_slot_dispatch_tick.sv =====
// ----------------------------------------------------------------------------
// thread_slot_dispatch_tick
// Execution slot dispatcher with a free-slot stack and a per-slot tick and preempt scan.
// ----------------------------------------------------------------------------
// A dispatch or an undefined operation is handled straight from idle; its
// single result is registered and shows on out_data with out_valid in the
// cycle after the start transfer, and busy stays low, so a new item may start
// in the next cycle. A tick or a preempt holds busy high for the whole scan:
// a small sequencer visits one slot per cycle in core-major order and runs it
// through one shared 16-bit decrementer (remaining time on a tick, priority
// on a preempt). Each freed slot gives one result, registered, in the cycle
// after its visit; a scan that frees nothing gives one "nothing happened"
// result after the last slot. out_valid is high for exactly one cycle per
// result and the receiver cannot stall; last marks each item's final result.
`include "thread_slot_dispatch_tick_macros.svh"

module thread_slot_dispatch_tick (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  tsd_pkg::tsd_in_t  in_data,
  output logic              out_valid,
  output tsd_pkg::tsd_out_t out_data
);
  import tsd_pkg::*;

  tsd_state_t state_r, state_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              any_r, any_nxt;

  logic [SLOTS-1:0]  slot_busy_r, slot_busy_nxt;
  logic [PROC_W-1:0] slot_proc_r [SLOTS];
  logic [PROC_W-1:0] slot_proc_nxt [SLOTS];
  logic [REM_W-1:0]  slot_rem_r [SLOTS];
  logic [REM_W-1:0]  slot_rem_nxt [SLOTS];
  logic [PRIO_W-1:0] slot_prio_r [SLOTS];
  logic [PRIO_W-1:0] slot_prio_nxt [SLOTS];
  logic [SLOT_W-1:0] free_stack_r [SLOTS];
  logic [SLOT_W-1:0] free_stack_nxt [SLOTS];
  logic [CNT_W-1:0]  free_count_r, free_count_nxt;

  logic     out_valid_r, out_valid_nxt;
  tsd_out_t out_r, out_nxt;

  logic [CNT_W-1:0]  top_idx;
  logic [SLOT_W-1:0] pop_slot;
  logic [REM_W-1:0]  dec_in, dec_out;
  logic [SLOTS-1:0]  event_vec;
  logic              more_events;
  logic              cur_event;
  logic              is_tick;
  logic              rem_zero;
  logic [PRIO_W-1:0] prio_new;

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign top_idx  = free_count_r - 1'b1;
  assign pop_slot = free_stack_r[top_idx[SLOT_W-1:0]];
  assign is_tick  = (op_r == OP_TICK);
  assign rem_zero = (slot_rem_r[idx_r] == '0);

  // shared decrementer
  assign dec_in  = is_tick ? slot_rem_r[idx_r] : REM_W'(slot_prio_r[idx_r]);
  assign dec_out = dec_in - 1'b1;
  assign prio_new = (slot_prio_r[idx_r] == '0) ? '0 : dec_out[PRIO_W-1:0];

  // which slots will free on this scan, to know whether a result is the last
  always_comb begin
    for (int t = 0; t < SLOTS; t++) begin
      event_vec[t] = slot_busy_r[t] && (!is_tick || (slot_rem_r[t] == '0));
    end
    more_events = 1'b0;
    for (int t = 0; t < SLOTS; t++) begin
      if (SLOT_W'(t) > idx_r && event_vec[t]) begin
        more_events = 1'b1;
      end
    end
    cur_event = event_vec[idx_r];
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    idx_nxt        = idx_r;
    any_nxt        = any_r;
    slot_busy_nxt  = slot_busy_r;
    slot_proc_nxt  = slot_proc_r;
    slot_rem_nxt   = slot_rem_r;
    slot_prio_nxt  = slot_prio_r;
    free_stack_nxt = free_stack_r;
    free_count_nxt = free_count_r;
    out_valid_nxt  = 1'b0;
    out_nxt        = out_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_nxt = '0;
          out_nxt.last = 1'b1;
          unique case (in_data.operation)
            OP_DISPATCH: begin
              out_valid_nxt = 1'b1;
              if (free_count_r == '0) begin
                out_nxt.out_kind = KIND_NO_SLOT;
              end else begin
                free_count_nxt          = top_idx;
                slot_busy_nxt[pop_slot] = 1'b1;
                slot_proc_nxt[pop_slot] = in_data.process_id;
                slot_rem_nxt[pop_slot]  = in_data.remaining_time;
                slot_prio_nxt[pop_slot] = in_data.priority_req;
                out_nxt.out_kind    = KIND_DISPATCHED;
                out_nxt.out_slot    = OUT_SLOT_W'(pop_slot);
                out_nxt.out_process = in_data.process_id;
              end
            end
            OP_TICK, OP_PREEMPT: begin
              state_nxt = ST_SCAN;
              op_nxt    = in_data.operation;
              idx_nxt   = '0;
              any_nxt   = 1'b0;
            end
            default: begin
              out_valid_nxt    = 1'b1;
              out_nxt.out_kind = KIND_NOTHING;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (slot_busy_r[idx_r] && is_tick && !rem_zero) begin
          slot_rem_nxt[idx_r] = dec_out;
        end
        if (cur_event) begin
          slot_busy_nxt[idx_r] = 1'b0;
          if (free_count_r < CNT_W'(SLOTS)) begin
            free_stack_nxt[free_count_r[SLOT_W-1:0]] = idx_r;
            free_count_nxt = free_count_r + 1'b1;
          end
          any_nxt             = 1'b1;
          out_valid_nxt       = 1'b1;
          out_nxt             = '0;
          out_nxt.out_slot    = OUT_SLOT_W'(idx_r);
          out_nxt.out_process = slot_proc_r[idx_r];
          out_nxt.last        = !more_events;
          if (is_tick) begin
            out_nxt.out_kind = KIND_FINISHED;
          end else begin
            slot_prio_nxt[idx_r]  = prio_new;
            out_nxt.out_kind      = KIND_PREEMPTED;
            out_nxt.out_remaining = slot_rem_r[idx_r];
            out_nxt.out_priority  = prio_new;
          end
        end
        if (idx_r == SLOT_W'(SLOTS - 1)) begin
          state_nxt = ST_IDLE;
          if (!any_r && !cur_event) begin
            out_valid_nxt    = 1'b1;
            out_nxt          = '0;
            out_nxt.out_kind = KIND_NOTHING;
            out_nxt.last     = 1'b1;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= OP_DISPATCH;
      idx_r        <= '0;
      any_r        <= 1'b0;
      slot_busy_r  <= '0;
      free_count_r <= CNT_W'(SLOTS);
      out_valid_r  <= 1'b0;
      for (int k = 0; k < SLOTS; k++) begin
        free_stack_r[k] <= SLOT_W'(SLOTS - 1 - k);
      end
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      idx_r        <= idx_nxt;
      any_r        <= any_nxt;
      slot_busy_r  <= slot_busy_nxt;
      free_count_r <= free_count_nxt;
      out_valid_r  <= out_valid_nxt;
      free_stack_r <= free_stack_nxt;
    end
  end

  // slot payload needs no reset
  always_ff @(posedge clk) begin
    slot_proc_r <= slot_proc_nxt;
    slot_rem_r  <= slot_rem_nxt;
    slot_prio_r <= slot_prio_nxt;
    out_r       <= out_nxt;
  end

  // every slot is either busy or on the free stack
  `TSD_ASSERT_ALWAYS(a_slot_conservation, (CNT_W'($countones(slot_busy_r)) + free_count_r) == CNT_W'(SLOTS))
  // a result that is not the last one comes while the scan still runs
  `TSD_ASSERT_SAME(a_not_last_while_scanning, out_valid && !out_data.last, busy)
  // a start transfer gives a result or a scan in the next cycle
  `TSD_ASSERT_NEXT(a_start_progress, start && !busy, out_valid || busy)

endmodule

// ===== bench/thread_slot_dispatch_tick_checker.sv =====
// ----------------------------------------------------------------------------
// thread_slot_dispatch_tick_checker
// Watches the request and result channels of the slot dispatcher. Each request
// transfer updates a private copy of the slot table and free stack and queues
// the slot events that it must cause. Each result is compared field by field
// with the oldest queued event.
// ----------------------------------------------------------------------------
module thread_slot_dispatch_tick_checker
  import tsd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     busy,
  input  tsd_in_t  in_data,
  input  logic     out_valid,
  input  tsd_out_t out_data,
  output int       fail_count,
  output int       pending,
  output int       checked
);

  logic              slot_taken [SLOTS];
  logic [PROC_W-1:0] slot_pid   [SLOTS];
  logic [REM_W-1:0]  slot_time  [SLOTS];
  logic [PRIO_W-1:0] slot_prio  [SLOTS];
  logic [SLOT_W-1:0] free_slots [SLOTS];
  int                free_depth;
  tsd_out_t          expected_events [$];
  int                fails = 0;
  int                compared = 0;

  function automatic tsd_out_t slot_event(logic [KIND_W-1:0] kind, int slot,
                                          logic [PROC_W-1:0] pid,
                                          logic [REM_W-1:0] rem,
                                          logic [PRIO_W-1:0] prio);
    tsd_out_t ev;
    ev.out_kind      = kind;
    ev.out_slot      = OUT_SLOT_W'(slot);
    ev.out_process   = pid;
    ev.out_remaining = rem;
    ev.out_priority  = prio;
    ev.last          = 1'b0;
    return ev;
  endfunction

  // a push onto a full stack is dropped
  function automatic void push_free_slot(int slot);
    if (free_depth < SLOTS) begin
      free_slots[free_depth] = SLOT_W'(slot);
      free_depth++;
    end
  endfunction

  function automatic void predict_slot_events(tsd_in_t req);
    tsd_out_t burst [SLOTS];
    int       n;
    int       s;
    n = 0;
    case (req.operation)
      OP_DISPATCH: begin
        if (free_depth == 0) begin
          burst[n] = slot_event(KIND_NO_SLOT, 0, '0, '0, '0);
          n++;
        end else begin
          free_depth--;
          s = int'(free_slots[free_depth]);
          slot_taken[s] = 1'b1;
          slot_pid[s]   = req.process_id;
          slot_time[s]  = req.remaining_time;
          slot_prio[s]  = req.priority_req;
          burst[n] = slot_event(KIND_DISPATCHED, s, req.process_id, '0, '0);
          n++;
        end
      end
      OP_TICK: begin
        for (s = 0; s < SLOTS; s++) begin
          if (slot_taken[s]) begin
            if (slot_time[s] != '0) begin
              slot_time[s] = slot_time[s] - 1'b1;
            end else begin
              slot_taken[s] = 1'b0;
              push_free_slot(s);
              burst[n] = slot_event(KIND_FINISHED, s, slot_pid[s], '0, '0);
              n++;
            end
          end
        end
      end
      OP_PREEMPT: begin
        for (s = 0; s < SLOTS; s++) begin
          if (slot_taken[s]) begin
            slot_taken[s] = 1'b0;
            if (slot_prio[s] != '0) slot_prio[s] = slot_prio[s] - 1'b1;
            push_free_slot(s);
            burst[n] = slot_event(KIND_PREEMPTED, s, slot_pid[s], slot_time[s],
                                  slot_prio[s]);
            n++;
          end
        end
      end
      default: ;
    endcase
    // quiet scan or undefined operation still answers once
    if (n == 0) begin
      burst[0] = slot_event(KIND_NOTHING, 0, '0, '0, '0);
      n = 1;
    end
    burst[n-1].last = 1'b1;
    for (int k = 0; k < n; k++) expected_events.push_back(burst[k]);
  endfunction

  function automatic void check_field(string name, logic [REM_W-1:0] want,
                                      logic [REM_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin
    tsd_out_t want;
    if (!rst_n) begin
      for (int k = 0; k < SLOTS; k++) begin
        slot_taken[k] = 1'b0;
        free_slots[k] = SLOT_W'(SLOTS - 1 - k);
      end
      free_depth = SLOTS;
      expected_events.delete();
    end else begin
      if (out_valid) begin
        if (expected_events.size() == 0) begin
          $error("result transfer with nothing expected: kind %0d slot %0d",
                 out_data.out_kind, out_data.out_slot);
          fails++;
        end else begin
          want = expected_events.pop_front();
          compared++;
          check_field("out_kind", want.out_kind, out_data.out_kind);
          check_field("out_slot", want.out_slot, out_data.out_slot);
          check_field("out_process", want.out_process, out_data.out_process);
          check_field("out_remaining", want.out_remaining, out_data.out_remaining);
          check_field("out_priority", want.out_priority, out_data.out_priority);
          check_field("last", want.last, out_data.last);
        end
      end
      if (start && !busy) predict_slot_events(in_data);
    end
    fail_count <= fails;
    pending    <= expected_events.size();
    checked    <= compared;
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the slot dispatcher with a directed run over full and empty stacks,
// quiet scans, saturating priorities and the undefined operation, then with
// random dispatch, tick and preempt traffic and random idle gaps. Checking is
// done by the checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import tsd_pkg::*;

  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
  localparam int RANDOM_ITEMS = 450;
  localparam int CYCLE_LIMIT  = 200000;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     start = 1'b0;
  logic     busy;
  tsd_in_t  in_data = '0;
  logic     out_valid;
  tsd_out_t out_data;
  int       fail_count;
  int       pending;
  int       checked;
  int       cycle_count = 0;
  int       ops_sent [4] = '{0, 0, 0, 0};
  tsd_in_t  directed_reqs [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  thread_slot_dispatch_tick u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  thread_slot_dispatch_tick_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic tsd_in_t make_request(logic [OP_W-1:0] op, logic [PROC_W-1:0] pid,
                                           logic [REM_W-1:0] rem,
                                           logic [PRIO_W-1:0] prio);
    tsd_in_t req;
    req.operation      = op;
    req.process_id     = pid;
    req.remaining_time = rem;
    req.priority_req   = prio;
    return req;
  endfunction

  // short run times so ticks free slots often, mostly dispatches so the
  // stack runs dry now and then
  function automatic tsd_in_t draw_scheduler_request();
    tsd_in_t req;
    int      pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)      req.operation = OP_DISPATCH;
    else if (pick < 85) req.operation = OP_TICK;
    else if (pick < 95) req.operation = OP_PREEMPT;
    else                req.operation = OP_UNDEFINED;
    req.process_id = PROC_W'($urandom);
    pick = $urandom_range(0, 9);
    if (pick < 7)      req.remaining_time = REM_W'($urandom_range(0, 3));
    else if (pick < 9) req.remaining_time = REM_W'($urandom_range(0, 40));
    else               req.remaining_time = REM_W'($urandom);
    if ($urandom_range(0, 4) == 0) req.priority_req = PRIO_W'($urandom_range(0, 1));
    else                           req.priority_req = PRIO_W'($urandom);
    return req;
  endfunction

  function automatic int idle_cycles(int item_no);
    int pick;
    pick = $urandom_range(0, 99);
    if (item_no % 64 < 16) return 0;
    if (pick < 50) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // holds start high until the transfer; start stays high across back-to-back items
  task automatic issue_request(input tsd_in_t req, input int gap);
    if (gap > 0) begin
      start   <= 1'b0;
      in_data <= draw_scheduler_request();
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    ops_sent[req.operation]++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    directed_reqs.push_back(make_request(OP_TICK, 8'hff, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_PREEMPT, 8'hff, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_UNDEFINED, 8'hff, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'hff, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h01, 16'h0001, 8'h01));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h80, 16'h0000, 8'h80));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h55, 16'h0002, 8'haa));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'haa, 16'h5555, 8'h55));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h7f, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'hfe, 16'haaaa, 8'hfe));
    // stack empty now
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'hff, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_TICK, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_TICK, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_PREEMPT, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h11, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h22, 16'h0001, 8'h01));
    directed_reqs.push_back(make_request(OP_DISPATCH, 8'h33, 16'hffff, 8'hff));
    directed_reqs.push_back(make_request(OP_UNDEFINED, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_TICK, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_PREEMPT, 8'h00, 16'h0000, 8'h00));
    directed_reqs.push_back(make_request(OP_PREEMPT, 8'h00, 16'h0000, 8'h00));

    foreach (directed_reqs[k]) issue_request(directed_reqs[k], idle_cycles(k));
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      issue_request(draw_scheduler_request(), idle_cycles(k));
    end
    start <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (SLOTS + 4) @(posedge clk);

    $display("requests: %0d dispatch, %0d tick, %0d preempt, %0d undefined",
             ops_sent[OP_DISPATCH], ops_sent[OP_TICK], ops_sent[OP_PREEMPT],
             ops_sent[OP_UNDEFINED]);
    $display("slot events compared: %0d", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
